/* sv/ofifo_pkg.sv */
package ofifo_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int CAP_W         = 6;
    localparam int CAP_DEFAULT   = 32;
    localparam int FILL_W        = 6;
    localparam int ID_W          = 32;
    localparam int WORD_W        = 64;
    localparam int PRIO_W        = 2;
    localparam int CAT_W         = 3;
    localparam int TAG_W         = PRIO_W + CAT_W;
    localparam int IN_TDATA_W    = 136;
    localparam int OUT_TDATA_W   = 176;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] time_ms;
        logic [WORD_W-1:0] metric;
        logic [TAG_W-1:0]  tags;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic load_mem;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic head_valid;
    } stat_t;

endpackage

/* sv/ofifo_ctrl.sv */
module ofifo_ctrl
    import ofifo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  cmd_t  cmd,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;
    logic   needs_read;

    assign needs_read = (cmd == CMD_POP || cmd == CMD_PEEK) && stat.head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && stat.out_free && needs_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        ctl.exec     = 1'b0;
        ctl.load_mem = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = stat.out_free;
                ctl.exec = s_tvalid && stat.out_free;
            end
            ST_READ:
            begin
                ctl.load_mem = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/ofifo_dp.sv */
module ofifo_dp
    import ofifo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    output stat_t             stat,
    input  cmd_t              cmd,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [CAT_W-1:0]  category,
    input  logic [WORD_W-1:0] metric_bits,
    input  logic [WORD_W-1:0] time_ms,
    input  logic              cfg_valid,
    input  logic [CAP_W-1:0]  cfg_data,
    input  logic              m_tready,
    output logic              out_valid,
    output logic              accepted,
    output logic              evicted,
    output logic [ID_W-1:0]   item_id,
    output logic [WORD_W-1:0] item_time_ms,
    output logic [PRIO_W-1:0] item_priority,
    output logic [CAT_W-1:0]  item_category,
    output logic [WORD_W-1:0] item_metric_bits,
    output logic [FILL_W-1:0] fill_count,
    output logic              now_empty,
    output logic              now_full
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = (AW > CAP_W) ? AW : CAP_W;
    localparam int CAP_RST = (CAP_DEFAULT > DEPTH) ? DEPTH : CAP_DEFAULT;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [CAP_W-1:0] c);
        logic [CW:0] n;
        n = (CW+1)'(p) + (CW+1)'(1);
        return (n >= (CW+1)'(c)) ? '0 : AW'(n);
    endfunction

    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] c;
        if (v == '0)
        begin
            c = CAP_W'(CAP_RST);
        end
        else if (int'(v) > DEPTH)
        begin
            c = CAP_W'(DEPTH);
        end
        else
        begin
            c = v;
        end
        return c;
    endfunction

    entry_t             mem_reg [DEPTH];
    entry_t             rd_data_reg;

    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      wr_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   cap_next;
    logic               out_valid_reg;

    logic               wr_en;
    logic               rd_en;
    logic               imm_load;
    logic               res_acc;
    logic               res_ev;
    entry_t             res_rec;

    logic               acc_reg;
    logic               ev_reg;
    entry_t             rec_reg;
    logic [FILL_W-1:0]  fill_out_reg;
    logic               empty_reg;
    logic               full_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        id_next     = id_reg;
        cap_next    = cap_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        imm_load    = 1'b0;
        res_acc     = 1'b0;
        res_ev      = 1'b0;
        res_rec     = '0;
        if (cfg_valid)
        begin
            cap_next    = eff_cap(cfg_data);
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
            id_next     = ID_W'(1);
        end
        else if (ctl.exec)
        begin
            unique case (cmd)
                CMD_PUSH:
                begin
                    wr_en    = 1'b1;
                    imm_load = 1'b1;
                    res_acc  = 1'b1;
                    if (fill_reg >= FILL_W'(cap_reg))
                    begin
                        res_ev      = 1'b1;
                        rd_ptr_next = advance(rd_ptr_reg, cap_reg);
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    wr_ptr_next     = advance(wr_ptr_reg, cap_reg);
                    id_next         = id_reg + ID_W'(1);
                    res_rec.id      = id_reg;
                    res_rec.time_ms = time_ms;
                    res_rec.metric  = metric_bits;
                    res_rec.tags    = {category, priority_req};
                end
                CMD_POP, CMD_PEEK:
                begin
                    if (fill_reg != '0)
                    begin
                        rd_en   = 1'b1;
                        res_acc = 1'b1;
                        if (cmd == CMD_POP)
                        begin
                            rd_ptr_next = advance(rd_ptr_reg, cap_reg);
                            fill_next   = fill_reg - FILL_W'(1);
                        end
                    end
                    else
                    begin
                        imm_load = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    imm_load    = 1'b1;
                    res_acc     = 1'b1;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    fill_next   = '0;
                end
                default:
                begin
                    imm_load = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            id_reg        <= ID_W'(1);
            cap_reg       <= CAP_W'(CAP_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            id_reg     <= id_next;
            cap_reg    <= cap_next;
            if (ctl.load_mem || imm_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= res_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            acc_reg      <= res_acc;
            ev_reg       <= res_ev;
            rec_reg      <= res_rec;
            fill_out_reg <= fill_next;
            empty_reg    <= (fill_next == '0);
            full_reg     <= (fill_next >= FILL_W'(cap_next));
        end
        else if (ctl.load_mem)
        begin
            rec_reg <= rd_data_reg;
        end
    end

    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.head_valid = (fill_reg != '0);

    assign out_valid        = out_valid_reg;
    assign accepted         = acc_reg;
    assign evicted          = ev_reg;
    assign item_id          = rec_reg.id;
    assign item_time_ms     = rec_reg.time_ms;
    assign item_priority    = rec_reg.tags[PRIO_W-1:0];
    assign item_category    = rec_reg.tags[TAG_W-1:PRIO_W];
    assign item_metric_bits = rec_reg.metric;
    assign fill_count       = fill_out_reg;
    assign now_empty        = empty_reg;
    assign now_full         = full_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(cap_reg))
        else $error("fill level above capacity");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW+1)'(rd_ptr_reg) < (CW+1)'(cap_reg))
        && ((CW+1)'(wr_ptr_reg) < (CW+1)'(cap_reg)))
        else $error("ring pointer outside capacity");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0 || fill_reg == FILL_W'(cap_reg)) |-> rd_ptr_reg == wr_ptr_reg)
        else $error("pointers disagree with fill level");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_mem |-> !out_valid_reg)
        else $error("memory result loaded over a pending transfer");
`endif

endmodule

/* sv/overwrite_oldest_ring_fifo.sv */
// Push, clear, and pop or peek on an empty ring: result registered in the cycle after the transfer in.
// Pop or peek on a held record: result through the registered memory read, then loaded in the read state.
// Throughput: one push or clear per cycle while the output is free; no new transfer is taken in the read state.
// A new transfer is taken while the previous result waits, once it drains that cycle.
// Asynchronous active-low reset empties the ring, sets the id to one and capacity to 32 (DEPTH if smaller).
module overwrite_oldest_ring_fifo
    import ofifo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // priority_req, category, metric_bits, time_ms
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // accepted, evicted, item_id, item_time_ms, item_priority, item_category,
    // item_metric_bits, fill_count, now_empty, now_full
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data
);

    ctl_t              ctl;
    stat_t             stat;
    cmd_t              cmd;
    logic              accepted;
    logic              evicted;
    logic [ID_W-1:0]   item_id;
    logic [WORD_W-1:0] item_time_ms;
    logic [PRIO_W-1:0] item_priority;
    logic [CAT_W-1:0]  item_category;
    logic [WORD_W-1:0] item_metric_bits;
    logic [FILL_W-1:0] fill_count;
    logic              now_empty;
    logic              now_full;

    assign cmd       = cmd_t'(s_tuser);
    assign cfg_ready = 1'b1;

    ofifo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    ofifo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .cmd              (cmd),
        .priority_req     (s_tdata[1:0]),
        .category         (s_tdata[4:2]),
        .metric_bits      (s_tdata[68:5]),
        .time_ms          (s_tdata[132:69]),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .m_tready         (m_tready),
        .out_valid        (m_tvalid),
        .accepted         (accepted),
        .evicted          (evicted),
        .item_id          (item_id),
        .item_time_ms     (item_time_ms),
        .item_priority    (item_priority),
        .item_category    (item_category),
        .item_metric_bits (item_metric_bits),
        .fill_count       (fill_count),
        .now_empty        (now_empty),
        .now_full         (now_full)
    );

    assign m_tdata = {1'b0, now_full, now_empty, fill_count, item_metric_bits,
                      item_category, item_priority, item_time_ms, item_id,
                      evicted, accepted};

endmodule
